// File: hdl/ebis_pkg.sv
package ebis_pkg;

	localparam int FUNC_BUTTONS = 4;
	localparam int NCH = FUNC_BUTTONS + 1;
	// result slots: encoder, encoder button, then function buttons
	localparam int NSLOT = NCH + 1;

	localparam int ACT_W = 3;
	localparam logic [ACT_W-1:0] ACT_LEFT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RIGHT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLICK = 3'd2;
	localparam logic [ACT_W-1:0] ACT_LONG = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FUNC0 = 3'd4;

	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_POLL = 2'd1;
	localparam logic [1:0] REG_LONG = 2'd2;

	localparam logic [7:0] DEBOUNCE_RST = 8'd4;
	localparam logic [9:0] POLL_RST = 10'd10;
	localparam logic [15:0] LONG_RST = 16'd800;

	localparam logic [16:0] HELD_MAX = 17'h1FFFF;

	localparam logic signed [3:0] STEP_POS = 4'sd4;
	localparam logic signed [3:0] STEP_NEG = -4'sd4;

	typedef logic signed [1:0] delta_t;

	// quadrature transition table, index {last, cur}
	function automatic delta_t step_delta(input logic [3:0] tr);
		delta_t d;
		case (tr)
			4'd1, 4'd7, 4'd8, 4'd14: d = 2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = -2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

// File: hdl/encoder_and_button_input_scanner.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   mode, enc_left_level, enc_right_level,
//                                 enc_button_level, func_button_levels
// out       out_valid / out_stall action, last_of_run
// cfg       cfg_write             cfg_index, cfg_data
//
// An input beat is registered, then decoded into a registered mask of up to six
// pending results; the results leave the output register one per cycle while
// out_stall is low. arst_n clears the control state and loads the register
// defaults (4, 10, 800). out_stall holds the output register and, once the
// pending mask is not empty, back-pressures the input through in_stall.
module encoder_and_button_input_scanner (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic                         enc_left_level,
	input  logic                         enc_right_level,
	input  logic                         enc_button_level,
	input  logic [ebis_pkg::FUNC_BUTTONS-1:0] func_button_levels,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ebis_pkg::ACT_W-1:0]   action,
	output logic                         last_of_run,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_data
);

	localparam int NCH = ebis_pkg::NCH;
	localparam int NSLOT = ebis_pkg::NSLOT;
	localparam int FB = ebis_pkg::FUNC_BUTTONS;

	// configuration
	logic [7:0]  debounce_q;
	logic [9:0]  poll_q;
	logic [15:0] long_q;

	// input stage
	logic          valid_s1;
	logic          mode_s1;
	logic [1:0]    enc_s1;
	logic          ebtn_s1;
	logic [FB-1:0] fbtn_s1;

	// scanner state
	logic [1:0]        enc_last_q;
	logic signed [2:0] enc_sum_q;
	logic [NCH-1:0]    stable_q;
	logic [NCH-1:0]    cand_q;
	logic [7:0]        cnt_q [NCH];
	logic              gest_active_q;
	logic              gest_long_q;
	logic [16:0]       held_q;

	// pending results
	logic [NSLOT-1:0] mask_q;
	logic             enc_right_q;
	logic             gest_is_long_q;

	// output register
	logic                       out_valid_q;
	logic [ebis_pkg::ACT_W-1:0] action_q;
	logic                       last_q;

	// next-state logic
	logic [NCH-1:0]    press;
	logic [7:0]        need;
	logic [NCH-1:0]    stable_n;
	logic [NCH-1:0]    cand_n;
	logic [7:0]        cnt_n [NCH];
	logic [7:0]        cnt_t [NCH];
	logic [NCH-1:0]    conf;
	logic [3:0]        tr;
	ebis_pkg::delta_t  delta;
	logic signed [3:0] sum_w;
	logic signed [2:0] sum_n;
	logic              enc_hit;
	logic              enc_right_n;
	logic              gest_active_n;
	logic              gest_long_n;
	logic [16:0]       held_n;
	logic [17:0]       held_sum;
	logic [16:0]       held_t;
	logic              gest_hit;
	logic              gest_is_long_n;
	logic [NSLOT-1:0]  mask_n;

	// pop logic
	logic                       pop_ok;
	logic [NSLOT-1:0]           low_bit;
	logic [NSLOT-1:0]           mask_left;
	logic [ebis_pkg::ACT_W-1:0] pop_act;
	logic                       adv_s1;
	logic                       accept;

	always_comb begin
		press[0] = ~ebtn_s1;
		for (int i = 0; i < FB; i++) begin
			press[i+1] = ~fbtn_s1[i];
		end
		need = (debounce_q == 8'd0) ? 8'd1 : debounce_q;

		for (int c = 0; c < NCH; c++) begin
			stable_n[c] = stable_q[c];
			cand_n[c] = cand_q[c];
			cnt_n[c] = cnt_q[c];
			cnt_t[c] = cnt_q[c];
			conf[c] = 1'b0;
			if (press[c] == stable_q[c]) begin
				cnt_n[c] = 8'd0;
				cand_n[c] = press[c];
			end else begin
				if (press[c] != cand_q[c]) begin
					cand_n[c] = press[c];
					cnt_t[c] = 8'd1;
				end else if (cnt_q[c] < need) begin
					cnt_t[c] = cnt_q[c] + 8'd1;
				end
				if (cnt_t[c] >= need) begin
					stable_n[c] = press[c];
					cnt_n[c] = 8'd0;
					conf[c] = press[c];
				end else begin
					cnt_n[c] = cnt_t[c];
				end
			end
		end

		// quadrature decode
		tr = {enc_last_q, enc_s1};
		delta = ebis_pkg::step_delta(tr);
		sum_w = {enc_sum_q[2], enc_sum_q} + {{2{delta[1]}}, delta};
		sum_n = enc_sum_q;
		enc_hit = 1'b0;
		enc_right_n = 1'b0;
		if (delta == 2'sd0) begin
			// both lines changed at once: position lost
			if (enc_s1 != enc_last_q) begin
				sum_n = 3'sd0;
			end
		end else if (sum_w >= ebis_pkg::STEP_POS) begin
			sum_n = 3'sd0;
			enc_hit = 1'b1;
			enc_right_n = 1'b1;
		end else if (sum_w <= ebis_pkg::STEP_NEG) begin
			sum_n = 3'sd0;
			enc_hit = 1'b1;
		end else begin
			sum_n = sum_w[2:0];
		end

		// encoder button gesture
		gest_active_n = gest_active_q;
		gest_long_n = gest_long_q;
		held_n = held_q;
		gest_hit = 1'b0;
		gest_is_long_n = 1'b0;
		held_sum = {1'b0, held_q} + {8'd0, poll_q};
		held_t = (held_sum > {1'b0, ebis_pkg::HELD_MAX}) ? ebis_pkg::HELD_MAX
			: held_sum[16:0];
		if (!stable_n[0]) begin
			gest_hit = gest_active_q && !gest_long_q;
			gest_active_n = 1'b0;
			gest_long_n = 1'b0;
			held_n = 17'd0;
		end else if (!gest_active_q) begin
			gest_active_n = 1'b1;
			gest_long_n = 1'b0;
			held_n = 17'd0;
		end else if (!gest_long_q) begin
			held_n = held_t;
			if (held_t >= {1'b0, long_q}) begin
				gest_long_n = 1'b1;
				gest_hit = 1'b1;
				gest_is_long_n = 1'b1;
			end
		end

		mask_n = {conf[NCH-1:1], gest_hit, enc_hit};
	end

	always_comb begin
		pop_ok = !out_valid_q || !out_stall;
		low_bit = mask_q & (~mask_q + NSLOT'(1));
		pop_act = ebis_pkg::ACT_LEFT;
		for (int s = NSLOT - 1; s >= 0; s--) begin
			if (mask_q[s]) begin
				if (s == 0) begin
					pop_act = enc_right_q ? ebis_pkg::ACT_RIGHT : ebis_pkg::ACT_LEFT;
				end else if (s == 1) begin
					pop_act = gest_is_long_q ? ebis_pkg::ACT_LONG : ebis_pkg::ACT_CLICK;
				end else begin
					pop_act = ebis_pkg::ACT_FUNC0 + ebis_pkg::ACT_W'(s - 2);
				end
			end
		end
		mask_left = pop_ok ? (mask_q & ~low_bit) : mask_q;
		adv_s1 = valid_s1 && (mask_left == '0);
		in_stall = valid_s1 && !adv_s1;
		accept = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= ebis_pkg::DEBOUNCE_RST;
			poll_q <= ebis_pkg::POLL_RST;
			long_q <= ebis_pkg::LONG_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				ebis_pkg::REG_DEBOUNCE: debounce_q <= cfg_data[7:0];
				ebis_pkg::REG_POLL: poll_q <= cfg_data[9:0];
				ebis_pkg::REG_LONG: long_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			enc_s1 <= {enc_left_level, enc_right_level};
			ebtn_s1 <= enc_button_level;
			fbtn_s1 <= func_button_levels;
		end
	end

	// state update, one beat per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_last_q <= 2'd0;
			enc_sum_q <= 3'sd0;
			stable_q <= '0;
			cand_q <= '0;
			for (int c = 0; c < NCH; c++) begin
				cnt_q[c] <= 8'd0;
			end
			gest_active_q <= 1'b0;
			gest_long_q <= 1'b0;
			held_q <= 17'd0;
			mask_q <= '0;
			enc_right_q <= 1'b0;
			gest_is_long_q <= 1'b0;
		end else begin
			if (adv_s1 && !mode_s1) begin
				mask_q <= mask_n;
			end else begin
				mask_q <= mask_left;
			end
			if (adv_s1) begin
				enc_last_q <= enc_s1;
				if (mode_s1) begin
					enc_sum_q <= 3'sd0;
					stable_q <= press;
					cand_q <= press;
					for (int c = 0; c < NCH; c++) begin
						cnt_q[c] <= 8'd0;
					end
					gest_active_q <= 1'b0;
					gest_long_q <= 1'b0;
					held_q <= 17'd0;
				end else begin
					enc_sum_q <= sum_n;
					stable_q <= stable_n;
					cand_q <= cand_n;
					for (int c = 0; c < NCH; c++) begin
						cnt_q[c] <= cnt_n[c];
					end
					gest_active_q <= gest_active_n;
					gest_long_q <= gest_long_n;
					held_q <= held_n;
					enc_right_q <= enc_right_n;
					gest_is_long_q <= gest_is_long_n;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			action_q <= ebis_pkg::ACT_LEFT;
			last_q <= 1'b0;
		end else if (pop_ok) begin
			out_valid_q <= (mask_q != '0);
			action_q <= pop_act;
			last_q <= ((mask_q & ~low_bit) == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign last_of_run = last_q;

endmodule
